>>> hdl/mbpf_pkg.sv
package mbpf_pkg;

    localparam int DEF_BANKS  = 8;
    localparam int DEF_LEVELS = 32;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int LVL_W  = 8;
    localparam int MASK_W = 8;
    localparam int POS_W  = 16;
    localparam int PROD_W = LVL_W + POS_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [CMD_W-1:0] CMD_SET_BANK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_BANK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FADE      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FADE,
        ST_HOLD
    } ctrl_state_t;

    typedef enum logic [1:0] {
        FD_IDLE,
        FD_MUL,
        FD_DIV,
        FD_DONE
    } fade_state_t;

    typedef struct packed {
        logic [LVL_W-1:0] start_level;
        logic [LVL_W-1:0] target_level;
        logic [POS_W-1:0] eased_position;
        logic [POS_W-1:0] span_total;
    } fade_req_t;

endpackage

>>> hdl/multi_bank_pwm_with_fader_unit.sv
// multi-bank pwm generator with fade-step interpolator
// input channel: in_valid/in_stall carry one command transaction with its fields
// (command, bank_index, level_value, start_level, target_level, eased_position,
// span_total). output channel: out_valid/out_stall carry one result transaction
// per command: drive_mask (mask last driven) and read_level (read data, else 0).
// set, set all, read, tick, all off and unused codes: if the receiver is not stalling,
// the result is in the output register the cycle after the command is taken, and such
// commands can be taken every cycle while the receiver keeps up.
// a fade step runs through the serial unit: a shift-add multiply by the position,
// one bit per cycle, then a restoring divide by span_total, one quotient bit per
// cycle; when span_total is zero both are skipped and the result is the clamped
// target_level. no new command is taken during a fade.
// when the receiver stalls, the output register holds its transaction and one
// more finished result can wait inside; the input then stalls until it drains.
// reset clears every bank duty, the phase counter and the mask, and leaves the
// output channel empty.
module multi_bank_pwm_with_fader_unit #(
    parameter int BANKS  = mbpf_pkg::DEF_BANKS,
    parameter int LEVELS = mbpf_pkg::DEF_LEVELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mbpf_pkg::CMD_W-1:0]    command,
    input  logic [mbpf_pkg::IDX_W-1:0]    bank_index,
    input  logic [mbpf_pkg::LVL_W-1:0]    level_value,
    input  logic [mbpf_pkg::LVL_W-1:0]    start_level,
    input  logic [mbpf_pkg::LVL_W-1:0]    target_level,
    input  logic [mbpf_pkg::POS_W-1:0]    eased_position,
    input  logic [mbpf_pkg::POS_W-1:0]    span_total,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbpf_pkg::MASK_W-1:0]   drive_mask,
    output logic [mbpf_pkg::LVL_W-1:0]    read_level
);
    import mbpf_pkg::*;

    localparam int BSEL_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam logic [LVL_W-1:0] LEV = LVL_W'(LEVELS);

    ctrl_state_t        state_reg, state_next;
    logic [LVL_W-1:0]   bank_reg [BANKS];
    logic [LVL_W-1:0]   bank_next [BANKS];
    logic [LVL_W-1:0]   phase_reg, phase_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [LVL_W-1:0]   pend_rd_reg, pend_rd_next;
    logic [BSEL_W-1:0]  fbank_reg, fbank_next;
    logic               frange_reg, frange_next;
    logic               out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]  drive_mask_reg, drive_mask_next;
    logic [LVL_W-1:0]   read_level_reg, read_level_next;

    logic               accept;
    logic               slot_free;
    logic               fade_go;
    logic               fade_done;
    logic [LVL_W-1:0]   fade_value;
    fade_req_t          fade_req;
    logic [BSEL_W-1:0]  bsel;
    logic               in_range;
    logic [LVL_W-1:0]   lvl_sat;
    logic [LVL_W-1:0]   rd;
    logic [MASK_W-1:0]  tick_mask;
    logic [LVL_W:0]     phase_inc;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign bsel      = bank_index[BSEL_W-1:0];
    assign in_range  = ({1'b0, bank_index} < (IDX_W + 1)'(BANKS));
    assign lvl_sat   = (level_value > LEV) ? LEV : level_value;
    assign phase_inc = {1'b0, phase_reg} + (LVL_W + 1)'(1);

    assign fade_req.start_level    = start_level;
    assign fade_req.target_level   = target_level;
    assign fade_req.eased_position = eased_position;
    assign fade_req.span_total     = span_total;

    mbpf_fade #(
        .LEVELS (LEVELS)
    ) u_fade (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (fade_go),
        .req   (fade_req),
        .done  (fade_done),
        .value (fade_value)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_FADE)
                    begin
                        state_next = ST_FADE;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_FADE:
            begin
                if (fade_done)
                begin
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        fade_go  = (state_reg == ST_IDLE) && in_valid && (command == CMD_FADE);
    end

    // tick mask, one compare per bank; banks past the mask width are dropped
    always_comb
    begin
        tick_mask = '0;
        for (int i = 0; i < BANKS; i++)
        begin
            if (i < MASK_W)
            begin
                tick_mask[i] = (bank_reg[i] > phase_reg);
            end
        end
    end

    // command datapath
    always_comb
    begin
        bank_next       = bank_reg;
        phase_next      = phase_reg;
        mask_next       = mask_reg;
        pend_rd_next    = pend_rd_reg;
        fbank_next      = fbank_reg;
        frange_next     = frange_reg;
        drive_mask_next = drive_mask_reg;
        read_level_next = read_level_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rd              = '0;

        if (accept)
        begin
            case (command)
                CMD_SET_BANK:
                begin
                    if (in_range)
                    begin
                        bank_next[bsel] = lvl_sat;
                    end
                end
                CMD_SET_ALL:
                begin
                    for (int i = 0; i < BANKS; i++)
                    begin
                        bank_next[i] = lvl_sat;
                    end
                end
                CMD_READ_BANK:
                begin
                    if (in_range)
                    begin
                        rd = bank_reg[bsel];
                    end
                end
                CMD_TICK:
                begin
                    mask_next  = tick_mask;
                    phase_next = (phase_inc >= (LVL_W + 1)'(LEVELS))
                               ? '0 : phase_inc[LVL_W-1:0];
                end
                CMD_FADE:
                begin
                    fbank_next  = bsel;
                    frange_next = in_range;
                end
                CMD_ALL_OFF:
                begin
                    for (int i = 0; i < BANKS; i++)
                    begin
                        bank_next[i] = '0;
                    end
                    mask_next = '0;
                end
                default:
                begin
                    rd = '0;
                end
            endcase

            if (command != CMD_FADE)
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    drive_mask_next = mask_next;
                    read_level_next = rd;
                end
                else
                begin
                    pend_rd_next = rd;
                end
            end
        end

        if ((state_reg == ST_FADE) && fade_done)
        begin
            if (frange_reg)
            begin
                bank_next[fbank_reg] = fade_value;
            end
            if (slot_free)
            begin
                out_valid_next  = 1'b1;
                drive_mask_next = mask_reg;
                read_level_next = '0;
            end
            else
            begin
                pend_rd_next = '0;
            end
        end

        if ((state_reg == ST_HOLD) && slot_free)
        begin
            out_valid_next  = 1'b1;
            drive_mask_next = mask_reg;
            read_level_next = pend_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BANKS; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            bank_reg      <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rd_reg    <= pend_rd_next;
        fbank_reg      <= fbank_next;
        frange_reg     <= frange_next;
        drive_mask_reg <= drive_mask_next;
        read_level_reg <= read_level_next;
    end

    assign out_valid  = out_valid_reg;
    assign drive_mask = drive_mask_reg;
    assign read_level = read_level_reg;

endmodule

>>> hdl/mbpf_fade.sv
module mbpf_fade #(
    parameter int LEVELS = mbpf_pkg::DEF_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  mbpf_pkg::fade_req_t          req,
    output logic                         done,
    output logic [mbpf_pkg::LVL_W-1:0]   value
);
    import mbpf_pkg::*;

    localparam logic [LVL_W-1:0] LEV = LVL_W'(LEVELS);

    fade_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LVL_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic [LVL_W-1:0]   start_reg, start_next;
    logic [LVL_W-1:0]   target_reg, target_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [POS_W:0]     rem_reg, rem_next;

    logic [POS_W:0]     trial;
    logic               qbit;
    logic [PROD_W:0]    sum;
    logic [LVL_W-1:0]   diff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FD_IDLE:
            begin
                if (go)
                begin
                    state_next = (req.span_total == '0) ? FD_DONE : FD_MUL;
                end
            end
            FD_MUL:
            begin
                if (cnt_reg == CNT_W'(POS_W - 1))
                begin
                    state_next = FD_DIV;
                end
            end
            FD_DIV:
            begin
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = FD_DONE;
                end
            end
            FD_DONE:
            begin
                state_next = FD_IDLE;
            end
            default:
            begin
                state_next = FD_IDLE;
            end
        endcase
    end

    // serial datapath: shift-add multiply by position, then restoring divide
    always_comb
    begin
        cnt_next    = cnt_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        start_next  = start_reg;
        target_next = target_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        trial       = {rem_reg[POS_W-1:0], acc_reg[PROD_W-1]};
        qbit        = (trial >= {1'b0, total_reg});
        case (state_reg)
            FD_IDLE:
            begin
                if (go)
                begin
                    neg_next    = (req.target_level < req.start_level);
                    mag_next    = (req.target_level < req.start_level)
                                ? req.start_level - req.target_level
                                : req.target_level - req.start_level;
                    zero_next   = (req.span_total == '0);
                    start_next  = req.start_level;
                    target_next = req.target_level;
                    pos_next    = req.eased_position;
                    total_next  = req.span_total;
                    acc_next    = '0;
                    rem_next    = '0;
                    cnt_next    = '0;
                end
            end
            FD_MUL:
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (pos_reg[POS_W-1] ? PROD_W'(mag_reg) : '0);
                pos_next = {pos_reg[POS_W-2:0], 1'b0};
                cnt_next = (cnt_reg == CNT_W'(POS_W - 1)) ? '0 : cnt_reg + 1'b1;
            end
            FD_DIV:
            begin
                rem_next = qbit ? trial - {1'b0, total_reg} : trial;
                acc_next = {acc_reg[PROD_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // outputs: apply sign of the span and clamp to 0..LEVELS; zero span_total gives the clamped target
    always_comb
    begin
        done  = (state_reg == FD_DONE);
        sum   = {1'b0, acc_reg} + (PROD_W + 1)'(start_reg);
        diff  = start_reg - acc_reg[LVL_W-1:0];
        if (zero_reg)
        begin
            value = (target_reg > LEV) ? LEV : target_reg;
        end
        else if (neg_reg)
        begin
            if (acc_reg >= PROD_W'(start_reg))
            begin
                value = '0;
            end
            else
            begin
                value = (diff > LEV) ? LEV : diff;
            end
        end
        else
        begin
            value = (sum > (PROD_W + 1)'(LEV)) ? LEV : sum[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        start_reg  <= start_next;
        target_reg <= target_next;
        pos_reg    <= pos_next;
        total_reg  <= total_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
    end

endmodule
